FILE: rtl/fgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fgr_pkg;

  // Font store geometry
  localparam int FONT_DEPTH    = 512;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int MAX_SCALE     = 8;
  localparam int FIRST_CODE    = 32;
  localparam int LAST_CODE     = 127;

  // Field widths
  localparam int COORD_W = 10;
  localparam int ACC_W   = COORD_W + 1;
  localparam int SIZE_W  = 4;
  localparam int COLOR_W = 16;
  localparam int CODE_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int ROW_W   = $clog2(GLYPH_ROWS);
  localparam int COL_W   = $clog2(GLYPH_COLUMNS);

  // Stream payload widths
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 48;

  // Configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // Reset values of the screen size registers
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 10'd240;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 10'd320;

  // Operation codes carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic rd_en;
    logic cell_eval;
    logic row_adv;
    logic col_adv;
    logic flush;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_draw;
    logic drop;
    logic cell_hit;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/fgr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fgr_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  fgr_pkg::dp_status_t  status_i,
  output fgr_pkg::ctrl_cmd_t   cmd_o
);

  fgr_pkg::state_e                state_q, state_d;
  logic [fgr_pkg::ROW_W-1:0]      row_q, row_d;
  logic [fgr_pkg::COL_W-1:0]      col_q, col_d;
  logic                           stall;
  logic                           last_row;
  logic                           last_col;

  assign last_row = (row_q == fgr_pkg::ROW_W'(fgr_pkg::GLYPH_ROWS - 1));
  assign last_col = (col_q == fgr_pkg::COL_W'(fgr_pkg::GLYPH_COLUMNS - 1));

  // Hold the walk when a new rectangle has nowhere to go
  assign stall = status_i.cell_hit && status_i.pend_valid && !status_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fgr_pkg::ST_IDLE: begin
        if (s_axis_tvalid && status_i.is_draw && !status_i.drop) begin
          state_d = fgr_pkg::ST_READ;
        end
      end
      fgr_pkg::ST_READ: begin
        state_d = fgr_pkg::ST_WALK;
      end
      fgr_pkg::ST_WALK: begin
        if (!stall && last_row) begin
          state_d = last_col ? fgr_pkg::ST_FLUSH : fgr_pkg::ST_READ;
        end
      end
      fgr_pkg::ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          state_d = fgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fgr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      fgr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid && !status_i.is_draw;
        cmd_o.start   = s_axis_tvalid && status_i.is_draw && !status_i.drop;
      end
      fgr_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      fgr_pkg::ST_WALK: begin
        cmd_o.cell_eval = !stall;
        cmd_o.row_adv   = !stall && !last_row;
        cmd_o.col_adv   = !stall && last_row && !last_col;
      end
      fgr_pkg::ST_FLUSH: begin
        cmd_o.flush = status_i.pend_valid && status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Cell counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_o.start) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_o.row_adv) begin
      row_d = row_q + 1'b1;
    end else if (cmd_o.col_adv) begin
      row_d = '0;
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fgr_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fgr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fgr_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire                               cfg_index_i,
  input  wire  [fgr_pkg::COORD_W-1:0]       cfg_data_i,
  input  wire  [fgr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  wire                               s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [fgr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast,
  input  fgr_pkg::ctrl_cmd_t                cmd_i,
  output fgr_pkg::dp_status_t               status_o
);

  localparam int CW = fgr_pkg::COORD_W;
  localparam int AW = fgr_pkg::ACC_W;
  localparam int SW = fgr_pkg::SIZE_W;
  localparam int KW = fgr_pkg::COLOR_W;
  localparam int FW = fgr_pkg::FONT_AW;

  // Unpacked input beat
  logic [FW-1:0]               in_addr;
  logic [fgr_pkg::BYTE_W-1:0]  in_byte;
  logic [CW-1:0]               in_px;
  logic [CW-1:0]               in_py;
  logic [fgr_pkg::CODE_W-1:0]  in_code;
  logic [KW-1:0]               in_fg;
  logic [KW-1:0]               in_bg;
  logic [SW-1:0]               in_scale;
  logic [SW-1:0]               in_scale_sat;
  logic [6:0]                  code_off;
  logic [FW-1:0]               glyph_base;

  // Configuration
  logic [CW-1:0] scr_w_q;
  logic [CW-1:0] scr_h_q;

  // Draw parameters and walk position
  logic [KW-1:0] fg_q, bg_q;
  logic [SW-1:0] scale_q;
  logic [CW-1:0] py_q;
  logic [AW-1:0] cx_q, cy_q;
  logic [FW-1:0] addr_q;
  logic [fgr_pkg::BYTE_W-1:0] bits_q;

  logic [fgr_pkg::BYTE_W-1:0] font_mem_q [fgr_pkg::FONT_DEPTH];

  // Cell evaluation
  logic          cell_set;
  logic          cell_on;
  logic          cell_hit;
  logic [AW-1:0] room_x, room_y;
  logic [SW-1:0] cell_w, cell_h;
  logic [KW-1:0] cell_color;

  // Pending rectangle and output register
  logic          pend_valid_q;
  logic [CW-1:0] pend_x_q, pend_y_q;
  logic [SW-1:0] pend_w_q, pend_h_q;
  logic [KW-1:0] pend_color_q;
  logic          out_valid_q;
  logic          out_last_q;
  logic [CW-1:0] out_x_q, out_y_q;
  logic [SW-1:0] out_w_q, out_h_q;
  logic [KW-1:0] out_color_q;
  logic          out_free;
  logic          push;

  assign in_addr  = s_axis_tdata[8:0];
  assign in_byte  = s_axis_tdata[16:9];
  assign in_px    = s_axis_tdata[26:17];
  assign in_py    = s_axis_tdata[36:27];
  assign in_code  = s_axis_tdata[44:37];
  assign in_fg    = s_axis_tdata[60:45];
  assign in_bg    = s_axis_tdata[76:61];
  assign in_scale = s_axis_tdata[80:77];

  assign in_scale_sat = (in_scale > SW'(fgr_pkg::MAX_SCALE)) ? SW'(fgr_pkg::MAX_SCALE)
                                                              : in_scale;

  // First font address of the glyph: (code - first) * 5 as shift and add
  assign code_off   = in_code[6:0] - 7'(fgr_pkg::FIRST_CODE);
  assign glyph_base = {code_off, 2'b00} + FW'(code_off);

  // Status toward the controller
  assign status_o.is_draw    = (s_axis_tuser == fgr_pkg::OP_DRAW);
  assign status_o.drop       = (in_px >= scr_w_q) || (in_py >= scr_h_q)
                             || (in_code < fgr_pkg::CODE_W'(fgr_pkg::FIRST_CODE))
                             || (in_code > fgr_pkg::CODE_W'(fgr_pkg::LAST_CODE))
                             || (in_scale == '0);
  assign status_o.cell_hit   = cell_hit;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  // Screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= fgr_pkg::SCREEN_WIDTH_RST;
      scr_h_q <= fgr_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == fgr_pkg::CFG_SCREEN_WIDTH) begin
        scr_w_q <= cfg_data_i;
      end
      if (cfg_index_i == fgr_pkg::CFG_SCREEN_HEIGHT) begin
        scr_h_q <= cfg_data_i;
      end
    end
  end

  // Font store: one write port for loads, one registered read for columns;
  // the column byte shifts down so bit 0 is always the current row
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      font_mem_q[in_addr] <= in_byte;
    end
    if (cmd_i.rd_en) begin
      bits_q <= font_mem_q[addr_q];
    end else if (cmd_i.row_adv) begin
      bits_q <= bits_q >> 1;
    end
  end

  // Latch draw parameters and advance the cell position
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      fg_q    <= in_fg;
      bg_q    <= in_bg;
      scale_q <= in_scale_sat;
      py_q    <= in_py;
      cx_q    <= AW'(in_px);
      cy_q    <= AW'(in_py);
      addr_q  <= glyph_base;
    end else if (cmd_i.col_adv) begin
      cx_q   <= cx_q + AW'(scale_q);
      cy_q   <= AW'(py_q);
      addr_q <= addr_q + 1'b1;
    end else if (cmd_i.row_adv) begin
      cy_q <= cy_q + AW'(scale_q);
    end
  end

  // Decide the current cell and clip it to the screen
  assign cell_set   = bits_q[0];
  assign cell_color = cell_set ? fg_q : bg_q;
  assign cell_on    = (cx_q < AW'(scr_w_q)) && (cy_q < AW'(scr_h_q));
  assign cell_hit   = cell_on && (cell_set || (bg_q != fg_q));
  assign room_x     = AW'(scr_w_q) - cx_q;
  assign room_y     = AW'(scr_h_q) - cy_q;
  assign cell_w     = (room_x < AW'(scale_q)) ? room_x[SW-1:0] : scale_q;
  assign cell_h     = (room_y < AW'(scale_q)) ? room_y[SW-1:0] : scale_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign push     = cmd_i.cell_eval && cell_hit;

  // Pending rectangle: it is known to be last only once the glyph ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (push) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_x_q     <= cx_q[CW-1:0];
      pend_y_q     <= cy_q[CW-1:0];
      pend_w_q     <= cell_w;
      pend_h_q     <= cell_h;
      pend_color_q <= cell_color;
    end
  end

  // Output register: take the pending beat when it is replaced or flushed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((push && pend_valid_q) || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((push && pend_valid_q) || cmd_i.flush) begin
      out_x_q     <= pend_x_q;
      out_y_q     <= pend_y_q;
      out_w_q     <= pend_w_q;
      out_h_q     <= pend_h_q;
      out_color_q <= pend_color_q;
      out_last_q  <= cmd_i.flush;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_color_q, out_h_q, out_w_q, out_y_q, out_x_q};

endmodule

`default_nettype wire

FILE: rtl/fixed_glyph_rasterizer.sv
// Channel   Dir  Contents
// s_axis    in   tuser: operation; tdata: font_address, glyph_bits, pos_x, pos_y,
//                char_code, fg_color, bg_color, scale
// m_axis    out  tdata: rect_x, rect_y, rect_width, rect_height, fill_color;
//                tlast: last
// cfg       in   cfg_we_i, cfg_index_i (0 screen_width, 1 screen_height), cfg_data_i
//
// A load beat writes the font store directly.
// A drawn character is walked column by column: per column, one font store
// read followed by the seven rows of that column, then one flush of the last
// rectangle. Dropped characters are taken without a walk.
// Reset restores the screen size to 240 x 320; the font store is not cleared.
// A stalled output holds the walk only when a new rectangle meets a full
// pending and output stage; input is taken again once the last beat is queued.
`timescale 1ns / 1ps
`default_nettype none

module fixed_glyph_rasterizer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire                              cfg_index_i,
  input  wire  [fgr_pkg::COORD_W-1:0]      cfg_data_i,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [8:0] font_address, [16:9] glyph_bits, [26:17] pos_x, [36:27] pos_y,
  // [44:37] char_code, [60:45] fg_color, [76:61] bg_color, [80:77] scale, [87:81] zero
  input  wire  [fgr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  wire                              s_axis_tuser,
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [9:0] rect_x, [19:10] rect_y, [23:20] rect_width, [27:24] rect_height,
  // [43:28] fill_color, [47:44] zero
  output logic [fgr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);

  fgr_pkg::ctrl_cmd_t  cmd;
  fgr_pkg::dp_status_t status;

  fgr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  fgr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status)
  );

`ifndef ASSERT_OFF
  // No rectangle may be left pending while new input is taken
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !status.pend_valid)
    else $error("pending rectangle left behind at idle");

  // Clipped sizes stay within one scaled cell
  a_rect_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:20] != 4'd0) && (m_axis_tdata[23:20] <= 4'd8)
                   && (m_axis_tdata[27:24] != 4'd0) && (m_axis_tdata[27:24] <= 4'd8))
    else $error("rectangle size out of range");

  // An accepted drawable character blocks input on the next cycle
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && status.is_draw && !status.drop)
      |=> !s_axis_tready)
    else $error("input taken while a character is walked");

  // A flush always hands over a last beat
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> m_axis_tvalid && m_axis_tlast)
    else $error("flush did not produce a last beat");
`endif

endmodule

`default_nettype wire

FILE: test/glyph_rect_checker.sv
`timescale 1ns / 1ps

module glyph_rect_checker
  import fgr_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_index_i,
  input  wire  [COORD_W-1:0]     cfg_data_i,
  input  wire                    s_axis_tvalid,
  input  wire                    s_axis_tready,
  // [8:0] font_address, [16:9] glyph_bits, [26:17] pos_x, [36:27] pos_y,
  // [44:37] char_code, [60:45] fg_color, [76:61] bg_color, [80:77] scale
  input  wire  [S_TDATA_W-1:0]   s_axis_tdata,
  // [0] operation
  input  wire                    s_axis_tuser,
  input  wire                    m_axis_tvalid,
  input  wire                    m_axis_tready,
  // [9:0] rect_x, [19:10] rect_y, [23:20] rect_width, [27:24] rect_height,
  // [43:28] fill_color
  input  wire  [M_TDATA_W-1:0]   m_axis_tdata,
  input  wire                    m_axis_tlast,
  output int                     pending_o,
  output int                     mismatches_o
);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [COLOR_W-1:0] color;
    logic               last;
  } glyph_rect_t;

  glyph_rect_t        expected_rects[$];
  logic [BYTE_W-1:0]  font_copy [FONT_DEPTH];
  logic [COORD_W-1:0] scr_w;
  logic [COORD_W-1:0] scr_h;
  int                 fail_count;

  // Walk the glyph column by column, top row first, and queue its rectangles
  task automatic rasterize_glyph(input logic [S_TDATA_W-1:0] d);
    int px, py, code, fg, bg, sc, col, row, cx, cy, wd, ht, first;
    logic [BYTE_W-1:0] bits;
    glyph_rect_t r;
    px = d[26:17];
    py = d[36:27];
    code = d[44:37];
    fg = d[60:45];
    bg = d[76:61];
    sc = d[80:77];
    first = expected_rects.size();
    // drop glyphs with an off-screen origin, a bad code or no size
    if (px >= scr_w || py >= scr_h || code < FIRST_CODE || code > LAST_CODE || sc == 0)
      return;
    if (sc > MAX_SCALE) sc = MAX_SCALE;
    for (col = 0; col < GLYPH_COLUMNS; col++) begin
      bits = font_copy[(code - FIRST_CODE) * GLYPH_COLUMNS + col];
      cx = px + col * sc;
      for (row = 0; row < GLYPH_ROWS; row++) begin
        cy = py + row * sc;
        if (!bits[row] && fg == bg) continue;
        if (cx >= scr_w || cy >= scr_h) continue;
        // clip against the right and bottom edges
        wd = (cx + sc > scr_w) ? scr_w - cx : sc;
        ht = (cy + sc > scr_h) ? scr_h - cy : sc;
        r.x = cx[COORD_W-1:0];
        r.y = cy[COORD_W-1:0];
        r.w = wd[SIZE_W-1:0];
        r.h = ht[SIZE_W-1:0];
        r.color = bits[row] ? fg[COLOR_W-1:0] : bg[COLOR_W-1:0];
        r.last = 1'b0;
        expected_rects.push_back(r);
      end
    end
    if (expected_rects.size() > first)
      expected_rects[expected_rects.size() - 1].last = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < FONT_DEPTH; i++) font_copy[i] = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    glyph_rect_t want;
    if (!rst_ni) begin
      expected_rects.delete();
      scr_w = SCREEN_WIDTH_RST;
      scr_h = SCREEN_HEIGHT_RST;
      fail_count = 0;
      pending_o <= 0;
      mismatches_o <= 0;
    end else begin
      // compare each output beat with the oldest expected rectangle
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rects.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected rectangle beat: data=%h last=%b", m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_rects.pop_front();
          if (m_axis_tdata[9:0] !== want.x || m_axis_tdata[19:10] !== want.y ||
              m_axis_tdata[23:20] !== want.w || m_axis_tdata[27:24] !== want.h ||
              m_axis_tdata[43:28] !== want.color || m_axis_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"rect mismatch: exp x=%0d y=%0d w=%0d h=%0d c=%h l=%b, ",
                        "got x=%0d y=%0d w=%0d h=%0d c=%h l=%b"},
                       want.x, want.y, want.w, want.h, want.color, want.last,
                       m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[23:20],
                       m_axis_tdata[27:24], m_axis_tdata[43:28], m_axis_tlast);
          end
        end
      end
      // track screen size writes
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SCREEN_WIDTH) scr_w = cfg_data_i;
        else scr_h = cfg_data_i;
      end
      // predict on every accepted input beat
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD) font_copy[s_axis_tdata[8:0]] = s_axis_tdata[16:9];
        else rasterize_glyph(s_axis_tdata);
      end
      pending_o <= expected_rects.size();
      mismatches_o <= fail_count;
    end
  end

endmodule

FILE: test/fixed_glyph_rasterizer_test.sv
`timescale 1ns / 1ps

module fixed_glyph_rasterizer_test;
  import fgr_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_PHASES   = 9;

  // screen settings, item counts and rush flags of the random phases
  localparam int PHASE_W     [NUM_PHASES] = '{1023, 1, 0,   240, 37, 240, 1023, 6,    128};
  localparam int PHASE_H     [NUM_PHASES] = '{1023, 1, 320, 0,   29, 320, 7,    1023, 64};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{60,   30, 12, 12,  70, 90,  50,   50,   80};
  localparam bit PHASE_RUSH  [NUM_PHASES] = '{0,    0, 0,   0,   1,  0,   0,    1,    0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_index_i;
  logic [COORD_W-1:0]   cfg_data_i;
  logic                 s_axis_tvalid;
  wire                  s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready;
  wire  [M_TDATA_W-1:0] m_axis_tdata;
  wire                  m_axis_tlast;
  int                   pending_rects;
  int                   mismatch_count;
  bit                   rush;
  bit                   hold_req;
  bit                   font_written [FONT_DEPTH];

  fixed_glyph_rasterizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  glyph_rect_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending_rects),
    .mismatches_o  (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [S_TDATA_W-1:0] pack_fields(
    logic [8:0] addr, logic [7:0] fbyte, logic [9:0] x, logic [9:0] y,
    logic [7:0] code, logic [15:0] fg, logic [15:0] bg, logic [3:0] sc);
    return {7'd0, sc, bg, fg, code, y, x, fbyte, addr};
  endfunction

  function automatic bit glyph_ready(logic [7:0] code);
    int base;
    base = (code - FIRST_CODE) * GLYPH_COLUMNS;
    for (int k = 0; k < GLYPH_COLUMNS; k++)
      if (!font_written[base + k]) return 1'b0;
    return 1'b1;
  endfunction

  // Pick a drawable code whose glyph is fully loaded; space is loaded up front
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    for (int i = 0; i < 24; i++) begin
      c = 8'($urandom_range(FIRST_CODE, LAST_CODE));
      if (glyph_ready(c)) return c;
    end
    return 8'(FIRST_CODE);
  endfunction

  // On-screen coordinate, biased toward the edges; limit must be nonzero
  function automatic logic [9:0] on_screen(int limit);
    case ($urandom_range(0, 3))
      0: return 10'($urandom_range(0, limit - 1));
      1: return 10'(limit - 1 - $urandom_range(0, (limit > 48) ? 47 : limit - 1));
      2: return 10'd0;
      default: return 10'($urandom_range(0, (limit > 64) ? 63 : limit - 1));
    endcase
  endfunction

  // Present one beat after a random gap (none when rushing) and hold it until taken
  task automatic push_item(input logic op, input logic [S_TDATA_W-1:0] data);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Load beat with junk in the draw fields
  task automatic send_load(input logic [8:0] addr, input logic [7:0] fbyte);
    font_written[addr] = 1'b1;
    push_item(OP_LOAD, pack_fields(addr, fbyte, 10'($urandom), 10'($urandom), 8'($urandom),
                                   16'($urandom), 16'($urandom), 4'($urandom)));
  endtask

  // Draw beat with junk in the load fields
  task automatic send_draw(input logic [9:0] x, input logic [9:0] y, input logic [7:0] code,
                           input logic [15:0] fg, input logic [15:0] bg, input logic [3:0] sc);
    push_item(OP_DRAW, pack_fields(9'($urandom), 8'($urandom), x, y, code, fg, bg, sc));
  endtask

  // Stop offering, wait for every rectangle, then let the walk settle
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_rects != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Output side: random stall per beat (none when rushing), one long hold-off on request
  initial begin : sink
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    int sent, kind, w, h;
    logic [7:0]  code;
    logic [9:0]  x, y;
    logic [15:0] fg, bg;
    logic [3:0]  sc;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_SCREEN_WIDTH;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_LOAD;
    rush = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: load space and the last code, plus the top of the store
    send_load(9'd0, 8'hFF);
    send_load(9'd1, 8'h00);
    send_load(9'd2, 8'h5A);
    send_load(9'd3, 8'hA5);
    send_load(9'd4, 8'h80);
    send_load(9'd475, 8'h01);
    send_load(9'd476, 8'h40);
    send_load(9'd477, 8'h3E);
    send_load(9'd478, 8'hFF);
    send_load(9'd479, 8'h00);
    send_load(9'd511, 8'hFF);
    send_load(9'd480, 8'h00);
    // plain, equal colors, saturated scale with clipping, corner
    send_draw(10'd0, 10'd0, 8'd32, 16'hFFFF, 16'h0000, 4'd1);
    send_draw(10'd10, 10'd20, 8'd127, 16'h1234, 16'h1234, 4'd8);
    send_draw(10'd235, 10'd315, 8'd32, 16'hF800, 16'h07E0, 4'd15);
    send_draw(10'd239, 10'd319, 8'd127, 16'hFFFF, 16'h0000, 4'd3);
    // origin off screen
    send_draw(10'd240, 10'd0, 8'd32, 16'h0001, 16'h8000, 4'd2);
    send_draw(10'd0, 10'd320, 8'd32, 16'h0001, 16'h8000, 4'd2);
    send_draw(10'd1023, 10'd1023, 8'd127, 16'h0001, 16'h8000, 4'd2);
    // codes outside the drawable range and zero scale
    send_draw(10'd5, 10'd5, 8'd31, 16'hAAAA, 16'h5555, 4'd1);
    send_draw(10'd5, 10'd5, 8'd128, 16'hAAAA, 16'h5555, 4'd1);
    send_draw(10'd5, 10'd5, 8'd255, 16'hAAAA, 16'h5555, 4'd1);
    send_draw(10'd5, 10'd5, 8'd0, 16'hAAAA, 16'h5555, 4'd1);
    send_draw(10'd5, 10'd5, 8'd32, 16'hAAAA, 16'h5555, 4'd0);
    finish_phase();

    // Random phases, each under its own screen size
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = PHASE_W[p];
      h = PHASE_H[p];
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_SCREEN_WIDTH;
      cfg_data_i <= 10'(w);
      @(posedge clk_i);
      cfg_index_i <= CFG_SCREEN_HEIGHT;
      cfg_data_i <= 10'(h);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      rush = PHASE_RUSH[p];
      if (rush) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS[p]) begin
        kind = $urandom_range(0, 99);
        fg = 16'($urandom);
        bg = ($urandom_range(0, 4) == 0) ? fg : 16'($urandom);
        sc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
        code = pick_char();
        if (kind < 6) begin
          send_load(9'($urandom), 8'($urandom));
          sent++;
        end else if (kind < 16) begin
          // refill one whole glyph with fresh column bits
          code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
          for (int k = 0; k < GLYPH_COLUMNS; k++)
            send_load(9'((code - FIRST_CODE) * GLYPH_COLUMNS + k), 8'($urandom));
          sent += GLYPH_COLUMNS;
        end else if (kind < 80 && w > 0 && h > 0) begin
          send_draw(on_screen(w), on_screen(h), code, fg, bg, sc);
          sent++;
        end else begin
          // noise: wild origin, code or scale
          x = 10'($urandom);
          y = 10'($urandom);
          if (w > 0 && $urandom_range(0, 1) == 1) x = on_screen(w);
          if (h > 0 && $urandom_range(0, 1) == 1) y = on_screen(h);
          case ($urandom_range(0, 2))
            0: code = 8'($urandom);
            1: sc = 4'($urandom);
            default: ;
          endcase
          if (code >= FIRST_CODE && code <= LAST_CODE && !glyph_ready(code)) code = pick_char();
          send_draw(x, y, code, fg, bg, sc);
          sent++;
        end
      end
      finish_phase();
    end

    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: fixed_glyph_rasterizer.f
rtl/fgr_pkg.sv
rtl/fgr_ctrl.sv
rtl/fgr_datapath.sv
rtl/fixed_glyph_rasterizer.sv
test/glyph_rect_checker.sv
test/fixed_glyph_rasterizer_test.sv
